// ===== hw/rtl/cma_pkg.sv =====
package cma_pkg;

  // Defaults for the top level parameters
  localparam int unsigned MAX_HALF_DEFAULT     = 15;
  localparam int unsigned SAMPLE_WIDTH_DEFAULT = 16;

  // Half width register
  localparam int unsigned HALF_WIDTH_BITS = 4;
  localparam logic [HALF_WIDTH_BITS-1:0] HALF_WIDTH_RESET = 4'd2;

  // Configuration port: one 32-bit register, word index in paddr[2]
  localparam int unsigned PADDR_WIDTH = 3;
  localparam int unsigned PDATA_WIDTH = 32;
  localparam logic [PADDR_WIDTH-3:0] REG_HALF_WIDTH = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_START,
    ST_READ,
    ST_DRAIN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DELIVER
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // write sample into the store, update counters
    logic start;      // set window extent, clear sum and read index
    logic rd;         // read the next store entry
    logic div_start;  // launch the divider on the finished sum
    logic out_load;   // load the quotient into the output register
    logic next_res;   // step the centre towards the newest sample
    logic finish;     // last result of this item has been loaded
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic due;          // this item owes at least one result
    logic last_read;    // current read is the oldest sample of the window
    logic div_done;     // divider has a quotient
    logic out_free;     // output register can take a result
    logic last_result;  // current result is the last one of this item
  } status_t;

endpackage

// ===== hw/rtl/cma_div.sv =====
module cma_div import cma_pkg::*; #(
  parameter int unsigned SUM_WIDTH = 21,
  parameter int unsigned DIV_WIDTH = 5,
  parameter int unsigned Q_WIDTH   = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [SUM_WIDTH-1:0] dividend,
  input  logic [DIV_WIDTH-1:0] divisor,
  output logic                 done,
  output logic [Q_WIDTH-1:0]   quotient
);

  localparam int unsigned CNT_WIDTH = $clog2(SUM_WIDTH + 1);

  logic                 busy;
  logic                 neg;
  logic [CNT_WIDTH-1:0] cnt;
  logic [DIV_WIDTH-1:0] rem;
  logic [DIV_WIDTH-1:0] den;
  logic [SUM_WIDTH-1:0] q;
  logic [DIV_WIDTH:0]   trial;
  logic [DIV_WIDTH:0]   diff;
  logic                 fits;
  logic [SUM_WIDTH-1:0] q_signed;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem, q[SUM_WIDTH-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = trial >= {1'b0, den};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_WIDTH'(SUM_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: divide magnitudes, restore the sign at the end
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_WIDTH-1];
      q   <= dividend[SUM_WIDTH-1] ? (~dividend + 1'b1) : dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
      q   <= {q[SUM_WIDTH-2:0], fits};
    end
  end

  assign q_signed = neg ? (~q + 1'b1) : q;
  assign quotient = q_signed[Q_WIDTH-1:0];

endmodule

// ===== hw/rtl/cma_dp.sv =====
module cma_dp import cma_pkg::*; #(
  parameter int unsigned MAX_HALF     = MAX_HALF_DEFAULT,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  cmd_t                           cmd,
  output status_t                        status,
  input  logic [HALF_WIDTH_BITS-1:0]     half_width,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           is_final,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] smoothed,
  output logic                           run_end,
  output logic                           set_end
);

  localparam int unsigned DEPTH = 2 * MAX_HALF + 2;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned SUMW  = SAMPLE_WIDTH + PW;
  localparam logic [PW-1:0] MAX_H = PW'(MAX_HALF);

  logic [SAMPLE_WIDTH-1:0] mem [DEPTH];
  logic [SAMPLE_WIDTH-1:0] rd_data;
  logic                    rd_pend;
  logic [PW-1:0]           wp;
  logic [CW-1:0]           seen;
  logic                    final_q;
  logic [PW-1:0]           h_q;
  logic [PW-1:0]           d;
  logic [PW-1:0]           far;
  logic [PW-1:0]           b;
  logic [SUMW-1:0]         sum;

  logic [PW-1:0]           h_clamp;
  logic [CW-1:0]           seen_inc;
  logic [PW-1:0]           newest_back;
  logic [PW-1:0]           d_init;
  logic [PW-1:0]           reach;
  logic [PW-1:0]           oldest;
  logic [PW:0]             addr_raw;
  logic [PW-1:0]           rd_addr;
  logic                    div_done;
  logic [SAMPLE_WIDTH-1:0] quotient;

  // Clamp the half width to the store's reach
  assign h_clamp = (32'(half_width) > MAX_HALF) ? MAX_H : PW'(half_width);

  // Sample count after this item, saturating at the store depth
  assign seen_inc    = (seen == CW'(DEPTH)) ? seen : seen + 1'b1;
  assign newest_back = PW'(seen_inc - 1'b1);

  // First centre: h back, or the oldest sample held when a short set ends
  assign d_init = (is_final && (newest_back < h_clamp)) ? newest_back : h_clamp;

  // Window extent in samples back from the newest, clipped to the set
  assign reach  = d + h_q;
  assign oldest = PW'(seen - 1'b1);

  // Store address of the entry b places older than the newest
  assign addr_raw = {1'b0, wp} + (PW + 1)'(DEPTH - 1) - {1'b0, b};
  assign rd_addr  = (addr_raw >= (PW + 1)'(DEPTH)) ? PW'(addr_raw - (PW + 1)'(DEPTH))
                                                   : addr_raw[PW-1:0];

  // Sample store
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[wp] <= sample;
    end
    if (cmd.rd) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Set bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      seen    <= '0;
      final_q <= 1'b0;
    end else if (cmd.accept) begin
      wp      <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      seen    <= seen_inc;
      final_q <= is_final;
    end else if (cmd.finish && final_q) begin
      seen <= '0;
    end
  end

  // Window control
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      h_q <= h_clamp;
      d   <= d_init;
    end else if (cmd.next_res) begin
      d <= d - 1'b1;
    end
    if (cmd.start) begin
      far <= (reach < oldest) ? reach : oldest;
      b   <= '0;
    end else if (cmd.rd) begin
      b <= b + 1'b1;
    end
  end

  // Accumulate one sample a cycle, in the cycle after its read
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sum <= '0;
    end else if (rd_pend) begin
      sum <= sum + {{PW{rd_data[SAMPLE_WIDTH-1]}}, rd_data};
    end
  end

  // Divide by the number of samples summed
  cma_div #(
    .SUM_WIDTH (SUMW),
    .DIV_WIDTH (PW),
    .Q_WIDTH   (SAMPLE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum),
    .divisor  (far + 1'b1),
    .done     (div_done),
    .quotient (quotient)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      smoothed <= quotient;
      run_end  <= status.last_result;
      set_end  <= final_q && (d == '0);
    end
  end

  assign status.due         = final_q || (seen > CW'(h_q));
  assign status.last_read   = (b == far);
  assign status.div_done    = div_done;
  assign status.out_free    = !out_valid || out_ready;
  assign status.last_result = !final_q || (d == '0);

endmodule

// ===== hw/rtl/cma_ctrl.sv =====
module cma_ctrl import cma_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = status.due ? ST_START : ST_IDLE;
      end
      ST_START: begin
        state_next = ST_READ;
      end
      ST_READ: begin
        if (status.last_read) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status.div_done) state_next = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (status.out_free) state_next = status.last_result ? ST_IDLE : ST_START;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_CHECK: begin
      end
      ST_START: begin
        cmd.start = 1'b1;
      end
      ST_READ: begin
        cmd.rd = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
      end
      ST_DIV_WAIT: begin
      end
      ST_DELIVER: begin
        cmd.out_load = status.out_free;
        cmd.next_res = status.out_free && !status.last_result;
        cmd.finish   = status.out_free && status.last_result;
      end
    endcase
  end

endmodule

// ===== hw/rtl/centered_moving_average_top.sv =====
// Centred moving average over a stream of signed Q8.8 samples. Each sample
// transfer writes the sample into a store of 2*MAX_HALF+2 entries. Once
// half_width samples of the set lie beyond a point, that point's mean is
// delivered; the transfer that carries is_final flushes every mean still owed
// (up to half_width+1 results, oldest first) and starts a new set. Windows are
// clipped to the samples of the current set and the mean is truncated toward
// zero. Each item is taken in and checked; each result it owes then reads
// the samples of its window through the store's one read port, one sample
// a cycle, and divides their sum, of width SAMPLE_WIDTH + clog2(2*MAX_HALF+2)
// = 21 bits by default, in a restoring divider that retires one quotient bit
// a cycle. A finished result waits in the output register while the next
// sample transfer is taken in. half_width is written through the register
// port at byte address 0 and should only change while the block is idle.
module centered_moving_average_top import cma_pkg::*; #(
  parameter int unsigned MAX_HALF     = MAX_HALF_DEFAULT,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [PADDR_WIDTH-1:0]         paddr,
  input  logic [PDATA_WIDTH-1:0]         pwdata,
  output logic [PDATA_WIDTH-1:0]         prdata,
  output logic                           pready,
  // sample channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           is_final,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] smoothed,
  output logic                           run_end,
  output logic                           set_end
);

  logic [HALF_WIDTH_BITS-1:0] half_width;
  logic                       reg_sel;
  cmd_t                       cmd;
  status_t                    status;

  // Register decode
  assign reg_sel = (paddr[PADDR_WIDTH-1:2] == REG_HALF_WIDTH);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_width <= HALF_WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      half_width <= pwdata[HALF_WIDTH_BITS-1:0];
    end
  end

  assign prdata = reg_sel ? PDATA_WIDTH'(half_width) : '0;

  cma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  cma_dp #(
    .MAX_HALF     (MAX_HALF),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .half_width (half_width),
    .sample     (sample),
    .is_final   (is_final),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .smoothed   (smoothed),
    .run_end    (run_end),
    .set_end    (set_end)
  );

  // A taken sample leaves the block busy in the cycle after the transfer
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample taken while the previous one was still being checked");

  // The end of a set is always the end of that item's run of results
  assert property (@(posedge clk) disable iff (rst)
    out_valid && set_end |-> run_end)
    else $error("set end flagged without run end");

  // Never overwrite a result that has not been transferred
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("output register loaded while still holding a result");

endmodule

// ===== bench/tb_centered_moving_average_top.sv =====
`timescale 1ns / 1ps

module tb_centered_moving_average_top;
  import cma_pkg::*;

  localparam int unsigned SW          = SAMPLE_WIDTH_DEFAULT;
  localparam int unsigned MAX_HALF    = MAX_HALF_DEFAULT;
  localparam int unsigned STORE_DEPTH = 2 * MAX_HALF + 2;
  localparam logic [PADDR_WIDTH-1:0] ADDR_HALF_WIDTH = {REG_HALF_WIDTH, 2'b00};
  // byte address of the word just past the register list; writes there must be dropped
  localparam logic [PADDR_WIDTH-1:0] ADDR_SPARE = PADDR_WIDTH'(4);
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned PRESSURE_HOLD = 300;
  localparam int unsigned RANDOM_ITEMS  = 160;

  typedef struct {
    logic signed [SW-1:0] smoothed;
    logic                 run_end;
    logic                 set_end;
  } average_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [PADDR_WIDTH-1:0] paddr = '0;
  logic [PDATA_WIDTH-1:0] pwdata = '0;
  logic [PDATA_WIDTH-1:0] prdata;
  logic                   pready;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic signed [SW-1:0]   sample = '0;
  logic                   is_final = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic signed [SW-1:0]   smoothed;
  logic                   run_end;
  logic                   set_end;

  // predictor state: sample history of the current set and the half width
  logic signed [SW-1:0]         hist [STORE_DEPTH];
  int unsigned                  hist_wr = 0;
  int unsigned                  hist_count = 0;
  logic [HALF_WIDTH_BITS-1:0]   cur_half = HALF_WIDTH_RESET;
  average_t                     pending_averages [$];

  int unsigned errors = 0;
  int unsigned results_checked = 0;
  int unsigned items_sent = 0;
  int unsigned sets_closed = 0;
  int unsigned hold_off_cycles = 0;
  logic [15:0] halves_seen = '0;
  bit          gaps_on = 1'b1;
  bit          stall_on = 1'b1;

  centered_moving_average_top u_top (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample    (sample),
    .is_final  (is_final),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .smoothed  (smoothed),
    .run_end   (run_end),
    .set_end   (set_end)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin : watchdog
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // mostly back to back, sometimes a few cycles, now and then a long pause
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SW-1:0] random_sample();
    int unsigned r;
    logic signed [SW-1:0] v;
    r = $urandom_range(0, 19);
    if (r < 2) return {1'b0, {(SW-1){1'b1}}};
    if (r < 4) return {1'b1, {(SW-1){1'b0}}};
    if (r < 7) begin
      v = SW'($urandom_range(0, 511));
      return v - SW'(256);
    end
    v = SW'($urandom());
    return v;
  endfunction

  // mean of the window centred 'centre' places back from the newest sample,
  // clipped to the samples of the current set, truncated toward zero
  function automatic logic signed [SW-1:0] clipped_mean(input int unsigned centre,
                                                        input int unsigned h);
    int unsigned far;
    longint total;
    longint q;
    far = centre + h;
    if (far > hist_count - 1) far = hist_count - 1;
    total = 0;
    for (int unsigned b = 0; b <= far; b++)
      total += hist[(hist_wr + STORE_DEPTH - 1 - b) % STORE_DEPTH];
    q = total / longint'(far + 1);
    return q[SW-1:0];
  endfunction

  // store one accepted sample and queue the averages it releases
  task automatic predict_averages(input logic signed [SW-1:0] s, input bit closes_set);
    int unsigned h;
    int unsigned d;
    average_t a;
    h = (cur_half > MAX_HALF) ? MAX_HALF : cur_half;
    hist[hist_wr] = s;
    hist_wr = (hist_wr + 1) % STORE_DEPTH;
    if (hist_count < STORE_DEPTH) hist_count++;
    if (!closes_set) begin
      if (hist_count > h) begin
        a.smoothed = clipped_mean(h, h);
        a.run_end  = 1'b1;
        a.set_end  = 1'b0;
        pending_averages = {pending_averages, a};
      end
    end else begin
      // flush every average still owed, oldest point first
      d = (h < hist_count - 1) ? h : hist_count - 1;
      for (int c = int'(d); c >= 0; c--) begin
        a.smoothed = clipped_mean(c, h);
        a.run_end  = (c == 0);
        a.set_end  = (c == 0);
        pending_averages = {pending_averages, a};
      end
      hist_count = 0;
      sets_closed++;
    end
  endtask

  // offer one sample; returns in the step of the transfer with valid still high
  task automatic send_sample(input logic signed [SW-1:0] s, input bit closes_set);
    int unsigned gap;
    gap = gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    is_final <= closes_set;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_averages(s, closes_set);
    items_sent++;
  endtask

  // drop valid, wait for every owed average, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_averages.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_WIDTH-1:0] addr,
                           input logic [PDATA_WIDTH-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [PADDR_WIDTH-1:0] addr,
                          output logic [PDATA_WIDTH-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_half_width();
    logic [PDATA_WIDTH-1:0] got;
    apb_read(ADDR_HALF_WIDTH, got);
    if (got !== PDATA_WIDTH'(cur_half))
      report_mismatch($sformatf("half_width reads %0d, expected %0d", got, cur_half));
  endtask

  task automatic set_half_width(input int unsigned h);
    settle();
    apb_write(ADDR_HALF_WIDTH, PDATA_WIDTH'(h));
    cur_half = HALF_WIDTH_BITS'(h);
    halves_seen[cur_half] = 1'b1;
    check_half_width();
  endtask

  // compare each result transfer with the oldest owed average
  always @(posedge clk) begin : result_check
    average_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_averages.size() == 0) begin
        report_mismatch($sformatf("average %0d with none owed", smoothed));
      end else begin
        want = pending_averages.pop_front();
        results_checked++;
        if (smoothed !== want.smoothed || run_end !== want.run_end ||
            set_end !== want.set_end)
          report_mismatch($sformatf("got %0d/%b/%b, expected %0d/%b/%b",
                                    smoothed, run_end, set_end,
                                    want.smoothed, want.run_end, want.set_end));
      end
    end
  end

  // result side: random stalls, plus a long hold when a test asks for one
  initial begin : result_sink
    int unsigned stall;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles) @(negedge clk);
        hold_off_cycles = 0;
      end
      if (stall_on && $urandom_range(0, 9) < 3) begin
        stall = 1 + pick_gap();
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // reset value, and a write past the register list that must be dropped
  task automatic test_register_port();
    halves_seen[cur_half] = 1'b1;
    check_half_width();
    apb_write(ADDR_SPARE, 32'h0000_0009);
    check_half_width();
  endtask

  // full-scale samples of both signs, zero and minus one at the reset width
  task automatic test_extreme_samples();
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'shffff, 1'b1);
  endtask

  // a lone final sample, then a set no longer than the half width
  task automatic test_short_sets();
    send_sample(16'sh0123, 1'b1);
    send_sample(-16'sd77, 1'b0);
    send_sample(16'sd300, 1'b1);
  endtask

  task automatic test_half_width_extremes();
    set_half_width(0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(-16'sd5, 1'b0);
    send_sample(16'sh8000, 1'b1);
    set_half_width(2 ** HALF_WIDTH_BITS - 1);
    send_sample(16'sd1000, 1'b0);
    send_sample(-16'sd999, 1'b0);
    send_sample(16'sh5a5a, 1'b0);
    send_sample(16'sha5a5, 1'b0);
    send_sample(16'sd3, 1'b1);
  endtask

  // narrow the window between two transfers of the same set
  task automatic test_width_change_mid_set();
    set_half_width(3);
    repeat (5) send_sample(random_sample(), 1'b0);
    set_half_width(1);
    send_sample(random_sample(), 1'b0);
    send_sample(random_sample(), 1'b0);
    send_sample(random_sample(), 1'b1);
  endtask

  // hold the result side off while samples keep coming, so the input stalls
  task automatic test_output_backpressure();
    set_half_width(1);
    gaps_on = 1'b0;
    hold_off_cycles = PRESSURE_HOLD;
    for (int k = 1; k <= 14; k++) send_sample(random_sample(), k == 14);
    gaps_on = 1'b1;
  endtask

  // whole sets of random length at random widths, with some loose samples
  task automatic test_random_sets();
    int unsigned count;
    int unsigned len;
    int unsigned h;
    int unsigned roll;
    count = 0;
    while (count < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 9);
      h = (roll == 0) ? 0 : (roll == 1) ? MAX_HALF : $urandom_range(0, MAX_HALF);
      set_half_width(h);
      gaps_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 99) < 85) begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 45)
                                            : $urandom_range(1, 2 * h + 4);
          for (int unsigned k = 1; k <= len; k++) send_sample(random_sample(), k == len);
          count += len;
        end else begin
          repeat ($urandom_range(1, 6)) begin
            send_sample(random_sample(), 1'($urandom_range(0, 1)));
            count++;
          end
        end
      end
    end
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin : stimulus
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_register_port();
    test_extreme_samples();
    test_short_sets();
    test_half_width_extremes();
    test_width_change_mid_set();
    test_output_backpressure();
    test_random_sets();
    settle();
    $display("Sent %0d samples over %0d closed sets; %0d averages checked.",
             items_sent, sets_closed, results_checked);
    $display("Half widths used: %0d of 16; gaps, stalls and a %0d-cycle output hold.",
             $countones(halves_seen), PRESSURE_HOLD);
    if (errors == 0 && pending_averages.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cma_pkg.sv
hw/rtl/cma_div.sv
hw/rtl/cma_dp.sv
hw/rtl/cma_ctrl.sv
hw/rtl/centered_moving_average_top.sv
bench/tb_centered_moving_average_top.sv
